FILE: sv/lms_pkg.sv
// shared constants, command and status types of the linear move splitter
package lms_pkg;

    localparam int AXES      = 4;   // axes that take part in a move
    localparam int NAX       = 4;   // axis fields on the ports
    localparam int POS_W     = 20;
    localparam int RATE_W    = 24;
    localparam int SPLIT_W   = 20;
    localparam int CNT_W     = 7;   // segment count, 1 to MAX_SEG
    localparam int J_W       = 6;   // point index, count-1 down to 0
    localparam int ACC_W     = 26;  // MAX_SEG * split distance
    localparam int REM_W     = 7;
    localparam int DIV_STEPS = 20;
    localparam int DSTEP_W   = 5;
    localparam int AX_W      = 2;
    localparam int TDATA_W   = NAX * POS_W + RATE_W;

    localparam logic [CNT_W-1:0]   MAX_SEG     = 7'd64;
    localparam logic [SPLIT_W-1:0] SPLIT_RESET = 20'd10000;
    localparam logic [AX_W-1:0]    AX_LAST     = AX_W'(AXES - 1);

    // action codes carried in s_tuser
    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic            capture;    // take a move transaction
        logic            load_pos;   // take a load transaction
        logic            max_step;   // fold one axis into the max distance
        logic            cnt_init;
        logic            cnt_step;
        logic            div_start;
        logic            div_store;
        logic            step;       // advance per-axis quotients one point
        logic            emit_mid;
        logic            emit_last;
        logic [AX_W-1:0] axis;
    } lms_cmd_t;

    typedef struct packed {
        logic cnt_done;
        logic div_done;
        logic j_zero;
        logic out_free;
    } lms_stat_t;

endpackage

FILE: sv/lms_div.sv
// shared restoring divider, one quotient bit per cycle
module lms_div import lms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [POS_W-1:0]   dividend,
    input  logic [CNT_W-1:0]   divisor,
    output logic               done,
    output logic [POS_W-1:0]   quot,
    output logic [REM_W-1:0]   rem
);

    logic [POS_W-1:0]   dq_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   div_reg;
    logic [DSTEP_W-1:0] step_reg;
    logic               run_reg;
    logic               done_reg;
    logic [REM_W-1:0]   shifted;
    logic               qbit;
    logic [REM_W-1:0]   rem_new;

    always_comb begin
        shifted = {rem_reg[REM_W-2:0], dq_reg[POS_W-1]};
        qbit    = (shifted >= div_reg);
        rem_new = qbit ? shifted - div_reg : shifted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DSTEP_W'(DIV_STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (run_reg) begin
            dq_reg  <= {dq_reg[POS_W-2:0], qbit};
            rem_reg <= rem_new;
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;
    assign rem  = rem_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sv/lms_datapath.sv
// position, distance, segment count and point datapath with output register
module lms_datapath import lms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  lms_cmd_t           cmd,
    output lms_stat_t          stat,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               cfg_valid,
    input  logic [SPLIT_W-1:0] cfg_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    pos_t               tgt_in  [NAX];
    logic [POS_W:0]     delta   [NAX];
    pos_t               mag_in  [NAX];

    pos_t               tgt_reg [NAX];
    pos_t               cur_reg [NAX];
    pos_t               mag_reg [NAX];
    logic               neg_reg [NAX];
    pos_t               qs_reg  [NAX];
    logic [REM_W-1:0]   rs2_reg [NAX];
    pos_t               q_reg   [NAX];
    logic [REM_W-1:0]   r_reg   [NAX];
    logic [RATE_W-1:0]  rate_reg;
    pos_t               max_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [J_W-1:0]     j_reg;
    logic [SPLIT_W-1:0] split_reg;

    pos_t               out_pt_reg [NAX];
    logic [RATE_W-1:0]  out_rate_reg;
    logic               out_last_reg;
    logic               out_valid_reg;

    logic [REM_W:0]     rtmp   [NAX];
    logic [REM_W:0]     two_n;
    pos_t               pt_mid [NAX];
    logic [POS_W:0]     pt_sum [NAX];
    logic               div_done;
    pos_t               div_quot;
    logic [REM_W-1:0]   div_rem;

    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            tgt_in[i] = s_tdata[i*POS_W +: POS_W];
            delta[i]  = {tgt_in[i][POS_W-1], tgt_in[i]} - {cur_reg[i][POS_W-1], cur_reg[i]};
            if (i < AXES) begin
                mag_in[i] = delta[i][POS_W] ? POS_W'(-delta[i]) : delta[i][POS_W-1:0];
            end else begin
                mag_in[i] = '0;
            end
        end
    end

    // next-point quotient and remainder, and the point value per axis
    always_comb begin
        two_n = {count_reg, 1'b0};
        for (int i = 0; i < NAX; i++) begin
            rtmp[i] = {1'b0, r_reg[i]} - {1'b0, rs2_reg[i]};
            if (neg_reg[i]) begin
                pt_sum[i] = {1'b0, tgt_reg[i]} + {1'b0, q_reg[i]};
            end else begin
                pt_sum[i] = {1'b0, tgt_reg[i]} - {1'b0, q_reg[i]};
            end
            pt_mid[i] = (i < AXES) ? pt_sum[i][POS_W-1:0] : '0;
        end
    end

    lms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (mag_reg[cmd.axis]),
        .divisor  (count_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_reg <= SPLIT_RESET;
            for (int i = 0; i < NAX; i++) begin
                cur_reg[i] <= '0;
            end
            count_reg     <= 7'd1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                split_reg <= cfg_data;
            end
            if (cmd.load_pos) begin
                for (int i = 0; i < AXES; i++) begin
                    cur_reg[i] <= tgt_in[i];
                end
            end
            if (cmd.emit_last) begin
                for (int i = 0; i < AXES; i++) begin
                    cur_reg[i] <= tgt_reg[i];
                end
            end
            if (cmd.cnt_init) begin
                count_reg <= 7'd1;
            end else if (cmd.cnt_step) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.emit_mid || cmd.emit_last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rate_reg <= s_tdata[NAX*POS_W +: RATE_W];
            max_reg  <= '0;
            for (int i = 0; i < NAX; i++) begin
                tgt_reg[i] <= tgt_in[i];
                mag_reg[i] <= mag_in[i];
                neg_reg[i] <= delta[i][POS_W];
            end
        end
        if (cmd.max_step && (mag_reg[cmd.axis] > max_reg)) begin
            max_reg <= mag_reg[cmd.axis];
        end
        if (cmd.cnt_init) begin
            acc_reg <= ACC_W'(split_reg);
        end else if (cmd.cnt_step) begin
            acc_reg <= acc_reg + ACC_W'(split_reg);
        end
        if (cmd.div_store) begin
            qs_reg[cmd.axis]  <= div_quot;
            rs2_reg[cmd.axis] <= {div_rem[REM_W-2:0], 1'b0};
            q_reg[cmd.axis]   <= mag_reg[cmd.axis];
            r_reg[cmd.axis]   <= count_reg;
            j_reg             <= J_W'(count_reg - 1'b1);
        end
        if (cmd.step) begin
            for (int i = 0; i < NAX; i++) begin
                if (rtmp[i][REM_W]) begin
                    r_reg[i] <= REM_W'(rtmp[i] + two_n);
                    q_reg[i] <= q_reg[i] - qs_reg[i] - 1'b1;
                end else begin
                    r_reg[i] <= rtmp[i][REM_W-1:0];
                    q_reg[i] <= q_reg[i] - qs_reg[i];
                end
            end
        end
        if (cmd.emit_mid) begin
            j_reg <= j_reg - 1'b1;
            for (int i = 0; i < NAX; i++) begin
                out_pt_reg[i] <= pt_mid[i];
            end
            out_rate_reg <= rate_reg;
            out_last_reg <= 1'b0;
        end
        if (cmd.emit_last) begin
            for (int i = 0; i < NAX; i++) begin
                out_pt_reg[i] <= (i < AXES) ? tgt_reg[i] : '0;
            end
            out_rate_reg <= rate_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_comb begin
        stat.cnt_done = (acc_reg >= ACC_W'(max_reg)) || (count_reg == MAX_SEG);
        stat.div_done = div_done;
        stat.j_zero   = (j_reg == '0);
        stat.out_free = !out_valid_reg || m_tready;
        for (int i = 0; i < NAX; i++) begin
            m_tdata[i*POS_W +: POS_W] = out_pt_reg[i];
        end
        m_tdata[NAX*POS_W +: RATE_W] = out_rate_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= MAX_SEG))
        else $error("segment count out of range");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_mid || cmd.emit_last) |-> stat.out_free)
        else $error("output register overwritten while held");
    a_last_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_last |=> (m_tvalid && m_tlast))
        else $error("final point not presented");
`endif

endmodule

FILE: sv/lms_ctrl.sv
// sequencing state machine of the linear move splitter
module lms_ctrl import lms_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_action,
    output logic      s_tready,
    input  lms_stat_t stat,
    output lms_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MAX     = 3'd1;
    localparam logic [2:0] S_CNT     = 3'd2;
    localparam logic [2:0] S_DIVGO   = 3'd3;
    localparam logic [2:0] S_DIVWAIT = 3'd4;
    localparam logic [2:0] S_STEP    = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;
    localparam logic [2:0] S_LAST    = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [AX_W-1:0] axis_reg, axis_next;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_action == ACT_LOAD) begin
                        cmd.load_pos = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        axis_next   = '0;
                        state_next  = S_MAX;
                    end
                end
            end
            S_MAX: begin
                cmd.max_step = 1'b1;
                if (axis_reg == AX_LAST) begin
                    cmd.cnt_init = 1'b1;
                    state_next   = S_CNT;
                end else begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            S_CNT: begin
                if (stat.cnt_done) begin
                    axis_next  = '0;
                    state_next = S_DIVGO;
                end else begin
                    cmd.cnt_step = 1'b1;
                end
            end
            S_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    if (axis_reg == AX_LAST) begin
                        state_next = S_STEP;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_DIVGO;
                    end
                end
            end
            S_STEP: begin
                if (stat.j_zero) begin
                    state_next = S_LAST;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_mid = 1'b1;
                    state_next   = S_STEP;
                end
            end
            S_LAST: begin
                if (stat.out_free) begin
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

`ifndef SYNTH
    a_step_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> (state_reg == S_EMIT))
        else $error("quotient step not followed by emit");
`endif

endmodule

FILE: sv/linear_move_splitter_unit.sv
// top level of the linear move splitter
//
// splits an absolute four-axis move into segments no longer than the
// configured split distance on any axis unless the cap of 64 segments per
// move is reached, and keeps the current position. a move transaction on
// the s_ side yields count points on the m_ side, the last one equal to the
// target and marked by m_tlast; a load transaction (s_tuser set) only sets
// the position and yields nothing. one transaction is worked at a time: a
// move passes the adder that searches the segment count one step per cycle,
// the shared divider that makes one quotient bit per cycle for each axis,
// and per emitted point a quotient step and an emit that waits while the
// output register is held. the next transaction is taken while the final
// point still waits in the output register. split_distance must be written
// on the cfg_ port (always ready) while idle; the block does not enforce it.
module linear_move_splitter_unit import lms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // input transactions
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // target_a, target_b, target_c, target_d, feed_rate
    input  logic [0:0]         s_tuser,   // action
    // result transactions
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // point_a, point_b, point_c, point_d, segment_rate
    output logic               m_tlast,   // last_segment
    // split distance register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SPLIT_W-1:0] cfg_data
);

    lms_cmd_t  cmd;
    lms_stat_t stat;

    // register writes are never held off
    assign cfg_ready = 1'b1;

    lms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser[0]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lms_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
